// File: rtl/apev2_pkg.sv
// Package for the APEv2 tag item parser: key table, field codes and widths.
// No dependencies; imported by apev2_tag_item_parser.
package apev2_pkg;

  localparam int MAX_KEY_LEN = 16;
  localparam int KEY_LEN_W   = $clog2(MAX_KEY_LEN + 1);
  localparam int NKEYS       = 9;
  localparam int KEY_CHARS   = 12;

  localparam logic [3:0] FC_NONE        = 4'd0;
  localparam logic [3:0] FC_TITLE       = 4'd1;
  localparam logic [3:0] FC_ARTIST      = 4'd2;
  localparam logic [3:0] FC_ALBUM       = 4'd3;
  localparam logic [3:0] FC_TRACK_NUM   = 4'd4;
  localparam logic [3:0] FC_TRACK_CNT   = 4'd5;
  localparam logic [3:0] FC_COMPOSER    = 4'd6;
  localparam logic [3:0] FC_COMMENT     = 4'd7;
  localparam logic [3:0] FC_YEAR        = 4'd8;
  localparam logic [3:0] FC_ALBUM_ART   = 4'd9;
  localparam logic [3:0] FC_GENRE       = 4'd10;

  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN [NKEYS] = '{
    KEY_LEN_W'(5), KEY_LEN_W'(6), KEY_LEN_W'(5), KEY_LEN_W'(5), KEY_LEN_W'(8),
    KEY_LEN_W'(7), KEY_LEN_W'(4), KEY_LEN_W'(12), KEY_LEN_W'(5)
  };

  localparam logic [3:0] KEY_CODE [NKEYS] = '{
    FC_TITLE, FC_ARTIST, FC_ALBUM, FC_TRACK_NUM, FC_COMPOSER,
    FC_COMMENT, FC_YEAR, FC_ALBUM_ART, FC_GENRE
  };

  // character at position pos of known key k (names padded to 12 chars)
  function automatic logic [7:0] key_char(input logic [3:0] k, input logic [3:0] pos);
    logic [8*KEY_CHARS-1:0] s;
    logic [7:0] ch;
    case (k)
      4'd0:    s = "TITLE       ";
      4'd1:    s = "ARTIST      ";
      4'd2:    s = "ALBUM       ";
      4'd3:    s = "TRACK       ";
      4'd4:    s = "COMPOSER    ";
      4'd5:    s = "COMMENT     ";
      4'd6:    s = "YEAR        ";
      4'd7:    s = "ALBUM ARTIST";
      4'd8:    s = "GENRE       ";
      default: s = '0;
    endcase
    if (pos < 4'(KEY_CHARS)) begin
      ch = s[(KEY_CHARS - 1 - int'(pos)) * 8 +: 8];
    end else begin
      ch = 8'h00;
    end
    return ch;
  endfunction

endpackage

// File: rtl/apev2_tag_item_parser.sv
// APEv2 tag item parser top level: byte-wide stream in, tagged value bytes out.
// Depends on apev2_pkg.
//
// Takes one tag body byte per cycle and gives at most one result per byte
// in the cycle after, from an output register; s_axis_tready is low only while
// that register holds a result not yet taken, so a stream at full rate with
// a ready sink runs at one byte per clock. Writing tag_size (index 0) or
// item_count (index 1) restarts parsing with the new counts; write only
// while no beat is in flight. After the end of the tag (tag_done seen) bytes
// are swallowed without results until the next register write.
module apev2_tag_item_parser
  import apev2_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] value_byte
  output logic [5:0]  m_axis_tuser,   // [3:0] field_code, [4] empty_value, [5] tag_done
  output logic        m_axis_tlast    // last_of_item
);

  typedef enum logic [2:0] {
    PH_LEN, PH_FLAGS, PH_KEY, PH_VALUE, PH_DONE
  } phase_t;

  typedef struct packed {
    logic [3:0] field_code;
    logic [7:0] value_byte;
    logic       empty_value;
    logic       last_of_item;
    logic       tag_done;
  } result_t;

  localparam logic [31:0] CFG_TAG_SIZE = 32'd0;

  logic [31:0] tag_size, item_count;
  phase_t parse_phase, parse_phase_next;
  logic [2:0]  header_byte_index, header_byte_index_next;
  logic [31:0] value_length, value_length_next;
  logic [31:0] value_left, value_left_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [31:0] items_left, items_left_next;
  logic [NKEYS-1:0] key_match_mask, key_match_mask_next;
  logic [KEY_LEN_W-1:0] key_length, key_length_next;
  logic slash_seen, slash_seen_next;
  logic number_seen, number_seen_next;
  logic [3:0] current_field, current_field_next;

  result_t res, out_res;
  logic    res_have, out_valid;
  logic    accept;

  logic [31:0] bytes_dec, vl, vleft;
  logic [2:0]  hdr_inc;
  logic [3:0]  match_code;
  logic [7:0]  upper;
  logic        have, item_end, stop, lflag;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    match_code = FC_NONE;
    for (int i = NKEYS - 1; i >= 0; i--) begin
      if (key_match_mask[i] && KEY_LEN[i] == key_length) begin
        match_code = KEY_CODE[i];
      end
    end
  end

  always_comb begin
    parse_phase_next       = parse_phase;
    header_byte_index_next = header_byte_index;
    value_length_next      = value_length;
    value_left_next        = value_left;
    bytes_left_next        = bytes_left;
    items_left_next        = items_left;
    key_match_mask_next    = key_match_mask;
    key_length_next        = key_length;
    slash_seen_next        = slash_seen;
    number_seen_next       = number_seen;
    current_field_next     = current_field;
    res       = '0;
    res_have  = 1'b0;
    have      = 1'b0;
    item_end  = 1'b0;
    stop      = 1'b0;
    lflag     = 1'b0;
    bytes_dec = bytes_left - 32'd1;
    hdr_inc   = header_byte_index + 3'd1;
    vl        = value_length;
    vleft     = value_left - 32'd1;
    upper     = (s_axis_tdata inside {[8'h61:8'h7a]}) ? s_axis_tdata - 8'h20 : s_axis_tdata;

    if (parse_phase == PH_DONE) begin
      res_have = 1'b0;
    end else if (parse_phase == PH_LEN && header_byte_index == 3'd0 &&
                 (bytes_left == 32'd0 || items_left == 32'd0)) begin
      parse_phase_next = PH_DONE;
      res_have         = 1'b1;
      res.tag_done     = 1'b1;
    end else begin
      bytes_left_next = bytes_dec;
      case (parse_phase)
        PH_LEN: begin
          if (header_byte_index == 3'd0) vl = '0;
          vl[header_byte_index[1:0] * 8 +: 8] = s_axis_tdata;
          value_length_next      = vl;
          header_byte_index_next = hdr_inc;
          if (hdr_inc >= 3'd4) begin
            header_byte_index_next = 3'd0;
            if ({1'b0, vl} > ({1'b0, bytes_dec} + 33'd4)) stop = 1'b1;
            else parse_phase_next = PH_FLAGS;
          end
        end
        PH_FLAGS: begin
          header_byte_index_next = hdr_inc;
          if (hdr_inc >= 3'd4) begin
            header_byte_index_next = 3'd0;
            parse_phase_next       = PH_KEY;
            key_match_mask_next    = '1;
            key_length_next        = '0;
          end
        end
        PH_KEY: begin
          if (s_axis_tdata == CH_NUL) begin
            current_field_next = match_code;
            value_left_next    = value_length;
            slash_seen_next    = 1'b0;
            number_seen_next   = 1'b0;
            if (value_length == 32'd0) begin
              if (match_code != FC_NONE) begin
                have            = 1'b1;
                res.field_code  = match_code;
                res.empty_value = 1'b1;
                lflag           = 1'b1;
              end
              item_end = 1'b1;
            end else begin
              parse_phase_next = PH_VALUE;
            end
          end else if (key_length >= KEY_LEN_W'(MAX_KEY_LEN)) begin
            key_match_mask_next = '0;
          end else begin
            for (int i = 0; i < NKEYS; i++) begin
              if (key_length >= KEY_LEN[i] ||
                  key_char(4'(i), key_length[3:0]) != upper) begin
                key_match_mask_next[i] = 1'b0;
              end
            end
            key_length_next = key_length + KEY_LEN_W'(1);
          end
        end
        PH_VALUE: begin
          value_left_next = vleft;
          lflag           = (vleft == 32'd0);
          if (current_field == FC_TRACK_NUM) begin
            if (!slash_seen && s_axis_tdata == CH_SLASH) begin
              slash_seen_next = 1'b1;
              if (!number_seen) begin
                have = 1'b1; res.field_code = FC_TRACK_NUM; res.empty_value = 1'b1;
              end else if (lflag) begin
                have = 1'b1; res.field_code = FC_TRACK_CNT; res.empty_value = 1'b1;
              end
            end else if (slash_seen) begin
              have = 1'b1; res.field_code = FC_TRACK_CNT; res.value_byte = s_axis_tdata;
            end else begin
              number_seen_next = 1'b1;
              have = 1'b1; res.field_code = FC_TRACK_NUM; res.value_byte = s_axis_tdata;
            end
          end else if (current_field != FC_NONE) begin
            have = 1'b1; res.field_code = current_field; res.value_byte = s_axis_tdata;
          end
          if (lflag) item_end = 1'b1;
        end
        default: begin
          parse_phase_next = PH_DONE;
        end
      endcase

      if (item_end) begin
        items_left_next        = items_left - 32'd1;
        parse_phase_next       = PH_LEN;
        header_byte_index_next = 3'd0;
        key_match_mask_next    = '1;
        key_length_next        = '0;
        if (items_left_next == 32'd0 || bytes_dec == 32'd0) stop = 1'b1;
      end else if (!stop && bytes_dec == 32'd0) begin
        stop = 1'b1;
        if (have) lflag = 1'b1;
      end

      res.last_of_item = have && lflag;
      if (stop) begin
        parse_phase_next = PH_DONE;
        if (!have) res = '0;
        res.tag_done = 1'b1;
      end
      res_have = have || stop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_size          <= '0;
      item_count        <= '0;
      parse_phase       <= PH_LEN;
      header_byte_index <= '0;
      value_length      <= '0;
      value_left        <= '0;
      bytes_left        <= '0;
      items_left        <= '0;
      key_match_mask    <= '1;
      key_length        <= '0;
      slash_seen        <= 1'b0;
      number_seen       <= 1'b0;
      current_field     <= FC_NONE;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_TAG_SIZE[0]) begin
          tag_size   <= cfg_data;
          bytes_left <= cfg_data;
          items_left <= item_count;
        end else begin
          item_count <= cfg_data;
          items_left <= cfg_data;
          bytes_left <= tag_size;
        end
        parse_phase       <= PH_LEN;
        header_byte_index <= '0;
        value_length      <= '0;
        value_left        <= '0;
        key_match_mask    <= '1;
        key_length        <= '0;
        slash_seen        <= 1'b0;
        number_seen       <= 1'b0;
        current_field     <= FC_NONE;
      end else if (accept) begin
        parse_phase       <= parse_phase_next;
        header_byte_index <= header_byte_index_next;
        value_length      <= value_length_next;
        value_left        <= value_left_next;
        bytes_left        <= bytes_left_next;
        items_left        <= items_left_next;
        key_match_mask    <= key_match_mask_next;
        key_length        <= key_length_next;
        slash_seen        <= slash_seen_next;
        number_seen       <= number_seen_next;
        current_field     <= current_field_next;
      end
      if (accept) out_valid <= res_have;
      else if (m_axis_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_res <= res;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_res.value_byte;
  assign m_axis_tuser  = {out_res.tag_done, out_res.empty_value, out_res.field_code};
  assign m_axis_tlast  = out_res.last_of_item;

  // a beat with no field code only ever marks the end of the tag
  a_marker_done: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[3:0] == FC_NONE |-> m_axis_tuser[5])
    else $error("result without field code lacks tag_done");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[4] |-> m_axis_tdata == 8'h00)
    else $error("empty value carries a data byte");

  a_done_sticks: assert property (@(posedge clk) disable iff (rst)
    accept && res_have && res.tag_done && !cfg_we |=> parse_phase == PH_DONE)
    else $error("parser not stopped after tag_done");

  a_key_len: assert property (@(posedge clk) disable iff (rst)
    key_length <= KEY_LEN_W'(MAX_KEY_LEN))
    else $error("key length past limit");

endmodule
